[rtl/core/fsr_pkg.sv]
// shared constants and types for the five-byte frame sync receiver
`timescale 1ns / 1ps

package fsr_pkg;

    localparam int FRAME_LEN = 5;
    localparam int WIN_DEPTH = FRAME_LEN - 1;
    localparam int WIN_IDX_W = $clog2(WIN_DEPTH);
    localparam int FILL_W    = 3;

    localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(WIN_DEPTH);

    localparam logic [7:0] HDR_BYTE  = 8'h01;
    localparam logic [7:0] MASK_HUNT = 8'h81;
    localparam logic [7:0] MASK_SYNC = 8'h80;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_WAIT    = 2'd0,
        ST_READY   = 2'd1,
        ST_BAD_HDR = 2'd2,
        ST_BAD_SUM = 2'd3
    } status_t;

    typedef struct packed {
        status_t                      status;
        logic [FRAME_LEN-1:0][7:0]    frame;
    } result_t;

endpackage

[rtl/core/fsr_front.sv]
// front end: byte window, frame checks and sync tracking
`timescale 1ns / 1ps

module fsr_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       data_byte,
    input  logic             queue_full,
    output logic             push,
    output fsr_pkg::result_t push_item
);
    import fsr_pkg::*;

    logic [7:0]                win_reg [WIN_DEPTH];
    logic [FILL_W-1:0]         fill_reg;
    logic [FILL_W-1:0]         fill_next;
    logic                      sync_reg;
    logic                      sync_next;
    logic                      accept;
    logic                      full;
    logic                      shift;
    logic [FRAME_LEN-1:0][7:0] frame;
    logic [7:0]                sum;
    logic                      sum_ok;
    logic                      hdr_hunt;
    logic                      hdr_sync;
    status_t                   status;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept;
    assign full     = (fill_reg >= FILL_LAST);

    always_comb
    begin
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            frame[i] = win_reg[i];
        end
        frame[FRAME_LEN-1] = data_byte;
    end

    assign sum      = frame[0] + frame[1] + frame[2] + frame[3];
    assign sum_ok   = (sum == frame[4]);
    assign hdr_hunt = (frame[0] == HDR_BYTE) && ((frame[1] & MASK_HUNT) == MASK_HUNT);
    assign hdr_sync = (frame[0] == HDR_BYTE) && ((frame[1] & MASK_SYNC) == MASK_SYNC);

    always_comb
    begin
        status    = ST_WAIT;
        fill_next = fill_reg;
        sync_next = sync_reg;
        shift     = 1'b0;
        if (!full)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (!sync_reg)
        begin
            if (hdr_hunt && sum_ok)
            begin
                sync_next = 1'b1;
                status    = ST_READY;
                fill_next = '0;
            end
            else
            begin
                // hunting: drop the oldest byte and keep looking
                shift     = 1'b1;
                fill_next = FILL_LAST;
            end
        end
        else if (!hdr_sync)
        begin
            sync_next = 1'b0;
            status    = ST_BAD_HDR;
            fill_next = '0;
        end
        else if (!sum_ok)
        begin
            sync_next = 1'b0;
            status    = ST_BAD_SUM;
            fill_next = '0;
        end
        else
        begin
            status    = ST_READY;
            fill_next = '0;
        end
    end

    assign push_item.status = status;
    assign push_item.frame  = (status == ST_WAIT) ? '0 : frame;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (!full)
            begin
                win_reg[fill_reg[WIN_IDX_W-1:0]] <= data_byte;
            end
            else if (shift)
            begin
                for (int i = 0; i < WIN_DEPTH - 1; i++)
                begin
                    win_reg[i] <= win_reg[i+1];
                end
                win_reg[WIN_DEPTH-1] <= data_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            sync_reg <= 1'b0;
        end
        else if (accept)
        begin
            fill_reg <= fill_next;
            sync_reg <= sync_next;
        end
    end

    // the window never holds more than four pending bytes
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_LAST)
        else $error("fill count out of range");

    // a good frame while hunting always gains sync
    a_gain_sync: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !sync_reg && status == ST_READY) |=> sync_reg)
        else $error("sync not gained on good frame");

endmodule

[rtl/core/fsr_queue.sv]
// short result queue between front and back
`timescale 1ns / 1ps

module fsr_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  fsr_pkg::result_t push_item,
    output logic             full,
    input  logic             pop,
    output fsr_pkg::result_t pop_item,
    output logic             empty
);
    import fsr_pkg::*;

    result_t           mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("pop from empty queue");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count lost a push");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

[rtl/core/fsr_back.sv]
// back end: output register that drains the result queue
`timescale 1ns / 1ps

module fsr_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             empty,
    input  fsr_pkg::result_t pop_item,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output fsr_pkg::result_t out_item
);
    import fsr_pkg::*;

    logic    out_valid_reg;
    result_t item_reg;

    assign pop       = !empty && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= pop_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule

[rtl/core/five_byte_frame_sync_receiver_core.sv]
// top level of the five-byte frame sync receiver
`timescale 1ns / 1ps

// usage
// - input channel: one serial byte per beat on data_byte, in_valid / in_ready
// - output channel: one result beat for every input beat, out_valid / out_ready,
//   carrying status (0 waiting, 1 frame ready, 2 bad header, 3 bad checksum)
//   and the five frame bytes, which read zero while status is waiting
// - the front end keeps the byte window, the fill count and the sync flag and
//   checks a complete frame in the cycle its last byte arrives
// - while hunting, a bad frame slides by one byte; a good one gains sync
// - in sync, a header or checksum failure drops sync and reports the frame;
//   every reported frame empties the window
// - result path: each result is written into the queue and then into the output
//   register, where out_valid rises; a full output register holds it in the queue
// - throughput: one beat per cycle while in_ready is high; the frame check is combinational
// - stall: a two-deep result queue plus the output register absorb three
//   results; after that in_ready drops until the consumer takes a beat
// - reset: window empty, hunting for sync, queue and output register empty

module five_byte_frame_sync_receiver_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic [7:0] frame_byte0,
    output logic [7:0] frame_byte1,
    output logic [7:0] frame_byte2,
    output logic [7:0] frame_byte3,
    output logic [7:0] frame_byte4
);
    import fsr_pkg::*;

    // front to queue
    logic    push;
    result_t push_item;
    logic    queue_full;

    // queue to back
    logic    pop;
    result_t pop_item;
    logic    queue_empty;

    result_t out_item;

    fsr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    fsr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (queue_empty)
    );

    fsr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (queue_empty),
        .pop_item  (pop_item),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // unpack the result beat onto the output ports
    assign status      = out_item.status;
    assign frame_byte0 = out_item.frame[0];
    assign frame_byte1 = out_item.frame[1];
    assign frame_byte2 = out_item.frame[2];
    assign frame_byte3 = out_item.frame[3];
    assign frame_byte4 = out_item.frame[4];

endmodule
